[design/mhs_pkg.sv]
`default_nettype none
package mhs_pkg;
    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int KID_W     = ADDR_W + 2;
    localparam int DATA_W    = 32;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [KID_W-1:0]         t_kid;
    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [2:0] {
        S_LOAD,
        S_BUILD_RD,
        S_BUILD_GET,
        S_SIFT,
        S_EXT_RD,
        S_EXT_WR,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

    // Heap children of a position, wide enough to hold indexes past the store.
    function automatic t_kid kid_left(input t_addr pos);
        kid_left = {1'b0, pos, 1'b1};
    endfunction

    function automatic t_kid kid_right(input t_addr pos);
        kid_right = {1'b0, pos, 1'b1} + t_kid'(1);
    endfunction
endpackage
`default_nettype wire

[design/mhs_ram.sv]
`default_nettype none
module mhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end
endmodule
`default_nettype wire

[design/min_heap_sorter.sv]
// min_heap_sorter: collects signed 32-bit values and returns them sorted in
// descending order. Input items arrive on i_valid/o_ready with i_value and
// i_last. Each accepted item is written to the value store.
// An item with i_last set, or the item that fills the store (MAX_ITEMS
// values), closes the set and, for two or more values, starts an in-place
// heapsort with a min-heap. While the block sorts and emits a set, o_ready
// stays low. Building the heap visits each inner node in turn: its value
// is read, then held while its two children are read, and then sifted down.
// Each of the N-1 extraction passes reads the root and the heap end, writes
// the root to the end, and sifts the old end value down from the root.
// In each level of a sift the two children are read together on the two read
// ports of the store while the chosen child is written back one level up.
// Results leave on o_valid/i_ready, each read from the store and then loaded
// into the output register. o_final_res marks the set's last result. When the
// receiver stalls, the result is held in the output register and the block
// waits; the last result of a set may still wait while the next set loads.
// Reset (i_rst_n low at a clock edge) empties the set and drops any pending
// result; the store itself is not cleared, as only written entries are read.
`default_nettype none
module min_heap_sorter (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire mhs_pkg::t_data i_value,
    input  wire logic           i_last,
    output logic                o_valid,
    input  wire logic           i_ready,
    output mhs_pkg::t_data      o_sorted_value,
    output logic                o_final_res
);
    import mhs_pkg::*;

    t_state r_state, n_state;
    t_cnt   r_cnt, n_cnt;      // values in the current set
    t_cnt   r_idx, n_idx;      // outer loop counter of build and extract
    t_cnt   r_size, n_size;    // current heap size
    t_addr  r_pos, n_pos;      // hole position of the running sift
    t_addr  r_k, n_k;          // output read position
    logic   r_build, n_build;  // heap build phase when set
    t_data  r_val, n_val;      // value being sifted down
    logic   r_ovalid, n_ovalid;
    t_data  r_odata, n_odata;
    logic   r_olast, n_olast;

    logic  ram_we;
    t_addr ram_waddr;
    t_data ram_wdata;
    t_addr ram_raddr_a, ram_raddr_b;
    t_data rd_a, rd_b;

    logic  in_acc, out_free, load_done;
    t_cnt  cnt_next, half, half_m1, idx_m2;
    t_kid  kl, kr, size_k, nkl, nkr;
    logic  take_l, take_r, move;
    t_data min_lv, child_val;
    t_addr child_pos;

    mhs_ram #(
        .WIDTH(DATA_W),
        .DEPTH(RAM_DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_raddr_a(ram_raddr_a),
        .i_raddr_b(ram_raddr_b),
        .o_rdata_a(rd_a),
        .o_rdata_b(rd_b)
    );

    assign o_ready        = (r_state == S_LOAD);
    assign in_acc         = i_valid && o_ready;
    assign out_free       = !r_ovalid || i_ready;
    assign o_valid        = r_ovalid;
    assign o_sorted_value = r_odata;
    assign o_final_res    = r_olast;

    assign cnt_next  = r_cnt + t_cnt'(1);
    assign load_done = i_last || (cnt_next == t_cnt'(MAX_ITEMS));
    assign half      = cnt_next >> 1;
    assign half_m1   = half - t_cnt'(1);
    assign idx_m2    = r_idx - t_cnt'(2);

    // One level of the sift: pick the smaller child if it beats the held value.
    always_comb begin
        kl        = kid_left(r_pos);
        kr        = kid_right(r_pos);
        size_k    = t_kid'(r_size);
        take_l    = (kl < size_k) && (rd_a < r_val);
        min_lv    = take_l ? rd_a : r_val;
        take_r    = (kr < size_k) && (rd_b < min_lv);
        move      = take_l || take_r;
        child_pos = take_r ? kr[ADDR_W-1:0] : kl[ADDR_W-1:0];
        child_val = take_r ? rd_b : rd_a;
        nkl       = kid_left(child_pos);
        nkr       = kid_right(child_pos);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_acc && load_done) begin
                    n_state = (cnt_next < t_cnt'(2)) ? S_OUT_RD : S_BUILD_RD;
                end
            end
            S_BUILD_RD:  n_state = S_BUILD_GET;
            S_BUILD_GET: n_state = S_SIFT;
            S_SIFT: begin
                if (!move) begin
                    if (r_build) begin
                        n_state = (r_idx == t_cnt'(1)) ? S_EXT_RD : S_BUILD_RD;
                    end else begin
                        n_state = (r_idx == t_cnt'(1)) ? S_OUT_RD : S_EXT_RD;
                    end
                end
            end
            S_EXT_RD: n_state = S_EXT_WR;
            S_EXT_WR: n_state = S_SIFT;
            S_OUT_RD: n_state = S_OUT_LD;
            S_OUT_LD: begin
                if (out_free) begin
                    n_state = ({1'b0, r_k} == r_cnt - t_cnt'(1)) ? S_LOAD : S_OUT_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_size      = r_size;
        n_pos       = r_pos;
        n_k         = r_k;
        n_build     = r_build;
        n_val       = r_val;
        n_odata     = r_odata;
        n_olast     = r_olast;
        n_ovalid    = r_ovalid && !i_ready;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_val;
        ram_raddr_a = r_k;
        ram_raddr_b = r_k;
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cnt[ADDR_W-1:0];
                    ram_wdata = i_value;
                    n_cnt     = cnt_next;
                    if (load_done) begin
                        n_idx   = half;
                        n_pos   = half_m1[ADDR_W-1:0];
                        n_size  = cnt_next;
                        n_build = 1'b1;
                        n_k     = '0;
                    end
                end
            end
            S_BUILD_RD: begin
                ram_raddr_a = r_pos;
            end
            S_BUILD_GET: begin
                n_val       = rd_a;
                ram_raddr_a = kl[ADDR_W-1:0];
                ram_raddr_b = kr[ADDR_W-1:0];
            end
            S_SIFT: begin
                // The hole moves down: the winner fills it, or the held value
                // settles there when neither child is smaller.
                ram_we      = 1'b1;
                ram_waddr   = r_pos;
                ram_wdata   = move ? child_val : r_val;
                ram_raddr_a = nkl[ADDR_W-1:0];
                ram_raddr_b = nkr[ADDR_W-1:0];
                if (move) begin
                    n_pos = child_pos;
                end else if (r_build) begin
                    if (r_idx == t_cnt'(1)) begin
                        n_build = 1'b0;
                        n_idx   = r_cnt - t_cnt'(1);
                    end else begin
                        n_idx = r_idx - t_cnt'(1);
                        n_pos = idx_m2[ADDR_W-1:0];
                    end
                end else begin
                    n_idx = r_idx - t_cnt'(1);
                end
            end
            S_EXT_RD: begin
                ram_raddr_a = '0;
                ram_raddr_b = r_idx[ADDR_W-1:0];
            end
            S_EXT_WR: begin
                // The root goes to the end of the heap; the old end value is
                // sifted down from the root of the shrunken heap.
                ram_we      = 1'b1;
                ram_waddr   = r_idx[ADDR_W-1:0];
                ram_wdata   = rd_a;
                n_val       = rd_b;
                n_pos       = '0;
                n_size      = r_idx;
                ram_raddr_a = kl[ADDR_W-1:0];
                ram_raddr_b = kr[ADDR_W-1:0];
                if (r_pos != '0) begin
                    ram_raddr_a = t_addr'(1);
                    ram_raddr_b = t_addr'(2);
                end
            end
            S_OUT_RD: begin
                ram_raddr_a = r_k;
            end
            S_OUT_LD: begin
                ram_raddr_a = r_k;
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = rd_a;
                    n_olast  = ({1'b0, r_k} == r_cnt - t_cnt'(1));
                    if ({1'b0, r_k} == r_cnt - t_cnt'(1)) begin
                        n_cnt = '0;
                    end else begin
                        n_k = r_k + t_addr'(1);
                    end
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_size   <= '0;
            r_pos    <= '0;
            r_k      <= '0;
            r_build  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_size   <= n_size;
            r_pos    <= n_pos;
            r_k      <= n_k;
            r_build  <= n_build;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_odata <= n_odata;
        r_olast <= n_olast;
    end
endmodule
`default_nettype wire
